@@ sv/hpack_literal_header_decoder_assert.svh @@
// assertion macros shared by the hpack literal header decoder modules
// needs nothing else; each file that asserts includes this header
`ifndef HPACK_LITERAL_HEADER_DECODER_ASSERT_SVH
`define HPACK_LITERAL_HEADER_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HLHD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HLHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hlhd_pkg.sv @@
// shared types and constants for the hpack literal header decoder
// no dependencies
`timescale 1ns / 1ps

package hlhd_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_EMPTY  = 3'd2,
        KIND_INCOMP = 3'd3,
        KIND_OVFL   = 3'd4
    } t_kind;

    // one queued result word from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    localparam int          LEN_W      = 32;
    localparam int          DIGIT_BITS = 7;
    localparam logic [6:0]  PREFIX_MAX = 7'h7F;
    localparam logic [2:0]  MAX_CONT   = 3'd5;
    localparam logic [4:0]  SHIFT_CAP  = 5'd28;

endpackage

@@ sv/hlhd_front.sv @@
// front end: accepts header block bytes, tracks field phase and lengths,
// and classifies each byte into at most one result word; uses hlhd_pkg
`timescale 1ns / 1ps

module hlhd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_block_end,
    input  logic               i_full,
    output logic               o_push,
    output hlhd_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        PH_REP   = 3'd0,
        PH_NLEN  = 3'd1,
        PH_NCONT = 3'd2,
        PH_NAME  = 3'd3,
        PH_VLEN  = 3'd4,
        PH_VCONT = 3'd5,
        PH_VALUE = 3'd6,
        PH_DROP  = 3'd7
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [hlhd_pkg::LEN_W-1:0]   r_acc, n_acc;
    logic [2:0]                   r_cnt, n_cnt;
    logic [hlhd_pkg::LEN_W-1:0]   r_left, n_left;

    logic                         accept;
    logic                         emit;
    hlhd_pkg::t_cmd               cmd;
    logic                         is_value;
    logic [4:0]                   shift;
    logic [hlhd_pkg::LEN_W-1:0]   digit;
    logic [hlhd_pkg::LEN_W-1:0]   sum;
    logic [2:0]                   cnt_inc;
    logic                         left_one;
    logic                         len_fin;
    logic [hlhd_pkg::LEN_W-1:0]   len_val;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && emit;
    assign o_cmd   = cmd;

    assign is_value = (r_phase == PH_VLEN) || (r_phase == PH_VCONT);
    assign digit    = {{(hlhd_pkg::LEN_W - hlhd_pkg::DIGIT_BITS){1'b0}}, i_in_byte[6:0]};
    assign cnt_inc  = r_cnt + 3'd1;
    assign left_one = (r_left == hlhd_pkg::LEN_W'(1));
    assign sum      = r_acc + (digit << shift);

    // 7 bits per continuation byte, capped
    always_comb begin
        unique case (r_cnt)
            3'd0:    shift = 5'd0;
            3'd1:    shift = 5'd7;
            3'd2:    shift = 5'd14;
            3'd3:    shift = 5'd21;
            default: shift = hlhd_pkg::SHIFT_CAP;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_left    = r_left;
        emit      = 1'b0;
        cmd.kind  = hlhd_pkg::KIND_NAME;
        cmd.data  = i_in_byte;
        cmd.last  = 1'b0;
        len_fin   = 1'b0;
        len_val   = '0;

        unique case (r_phase)
            PH_REP: begin
                n_phase = PH_NLEN;
                if (i_block_end) begin
                    emit     = 1'b1;
                    cmd.kind = hlhd_pkg::KIND_INCOMP;
                    n_phase  = PH_REP;
                end
            end
            PH_NLEN, PH_VLEN: begin
                if (i_in_byte[6:0] != hlhd_pkg::PREFIX_MAX) begin
                    len_fin = 1'b1;
                    len_val = digit;
                end else begin
                    n_acc   = {{(hlhd_pkg::LEN_W - 7){1'b0}}, hlhd_pkg::PREFIX_MAX};
                    n_cnt   = '0;
                    n_phase = is_value ? PH_VCONT : PH_NCONT;
                    if (i_block_end) begin
                        emit     = 1'b1;
                        cmd.kind = hlhd_pkg::KIND_INCOMP;
                        n_phase  = PH_REP;
                    end
                end
            end
            PH_NCONT, PH_VCONT: begin
                n_acc = sum;
                n_cnt = cnt_inc;
                if (!i_in_byte[7]) begin
                    len_fin = 1'b1;
                    len_val = sum;
                end else if (cnt_inc >= hlhd_pkg::MAX_CONT) begin
                    emit     = 1'b1;
                    cmd.kind = hlhd_pkg::KIND_OVFL;
                    n_phase  = i_block_end ? PH_REP : PH_DROP;
                end else if (i_block_end) begin
                    emit     = 1'b1;
                    cmd.kind = hlhd_pkg::KIND_INCOMP;
                    n_phase  = PH_REP;
                end
            end
            PH_NAME: begin
                emit = 1'b1;
                if (i_block_end) begin
                    cmd.kind = hlhd_pkg::KIND_INCOMP;
                    n_phase  = PH_REP;
                end else begin
                    cmd.kind = hlhd_pkg::KIND_NAME;
                    cmd.last = left_one;
                    n_left   = r_left - hlhd_pkg::LEN_W'(1);
                    if (left_one) begin
                        n_phase = PH_VLEN;
                    end
                end
            end
            PH_VALUE: begin
                emit = 1'b1;
                if (i_block_end && !left_one) begin
                    cmd.kind = hlhd_pkg::KIND_INCOMP;
                    n_phase  = PH_REP;
                end else begin
                    cmd.kind = hlhd_pkg::KIND_VALUE;
                    cmd.last = left_one;
                    n_left   = r_left - hlhd_pkg::LEN_W'(1);
                    if (left_one) begin
                        n_phase = PH_REP;
                    end
                end
            end
            PH_DROP: begin
                if (i_block_end) begin
                    n_phase = PH_REP;
                end
            end
        endcase

        // length complete: load the string counter
        if (len_fin) begin
            n_acc  = '0;
            n_cnt  = '0;
            n_left = len_val;
            if (is_value && (len_val == '0)) begin
                emit     = 1'b1;
                cmd.kind = hlhd_pkg::KIND_EMPTY;
                cmd.last = 1'b1;
                n_phase  = PH_REP;
            end else begin
                if (is_value) begin
                    n_phase = PH_VALUE;
                end else begin
                    n_phase = (len_val == '0) ? PH_VLEN : PH_NAME;
                end
                if (i_block_end) begin
                    emit     = 1'b1;
                    cmd.kind = hlhd_pkg::KIND_INCOMP;
                    n_phase  = PH_REP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_REP;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
        end
    end

endmodule

@@ sv/hlhd_queue.sv @@
// short first-word-fall-through queue of result words between front and back
// uses hlhd_pkg for the word type and the shared assertion header
`timescale 1ns / 1ps

`include "hpack_literal_header_decoder_assert.svh"

module hlhd_queue #(
    parameter int DEPTH = 4     // 2 to 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hlhd_pkg::t_cmd  i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output hlhd_pkg::t_cmd  o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hlhd_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `HLHD_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0,
        "pop from empty queue")
    `HLHD_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, i_push, r_count != CNT_W'(DEPTH),
        "push into full queue")
    `HLHD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + CNT_W'(1), "queue count did not grow on push")

endmodule

@@ sv/hlhd_back.sv @@
// back end: pops result words and formats them into the output register
// uses hlhd_pkg and the shared assertion header
`timescale 1ns / 1ps

`include "hpack_literal_header_decoder_assert.svh"

module hlhd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  hlhd_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_string_end,
    output logic            o_field_end
);

    logic        r_valid;
    logic [2:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_send;
    logic        r_fend;
    logic        load;
    logic        is_str;
    logic        is_val;
    logic        is_empty;

    // refill whenever the output register is free or being taken
    assign load     = !i_empty && (!r_valid || !i_stall);
    assign o_pop    = load;
    assign is_val   = (i_cmd.kind == hlhd_pkg::KIND_VALUE);
    assign is_str   = (i_cmd.kind == hlhd_pkg::KIND_NAME) || is_val;
    assign is_empty = (i_cmd.kind == hlhd_pkg::KIND_EMPTY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_cmd.kind;
            r_byte <= is_str ? i_cmd.data : 8'h00;
            r_send <= is_str && i_cmd.last;
            r_fend <= (is_val && i_cmd.last) || is_empty;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_string_end = r_send;
    assign o_field_end  = r_fend;

    `HLHD_ASSERT_SAME(a_empty_fmt, i_clk, i_rst_n,
        r_valid && (r_kind == hlhd_pkg::KIND_EMPTY),
        r_fend && !r_send && (r_byte == 8'h00), "empty value word badly formed")
    `HLHD_ASSERT_SAME(a_fend_kind, i_clk, i_rst_n, r_valid && r_fend,
        ((r_kind == hlhd_pkg::KIND_VALUE) && r_send) || (r_kind == hlhd_pkg::KIND_EMPTY),
        "field end on wrong kind")
    `HLHD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_valid && i_stall,
        r_valid && $stable(r_kind) && $stable(r_byte) && $stable(r_send) && $stable(r_fend),
        "stalled result word changed")

endmodule

@@ sv/hpack_literal_header_decoder.sv @@
// top level of the hpack literal header decoder: front end, result queue, back end
// depends on hlhd_pkg, hlhd_front, hlhd_queue and hlhd_back
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------------------
//   input   | in  | i_valid / o_stall | i_in_byte[7:0], i_block_end
//   output  | out | o_valid / i_stall | o_kind[2:0], o_out_byte[7:0], o_string_end, o_field_end
//
// one byte per cycle while o_stall is low; a result word reaches the outputs through the queue
//   and the output register (the accepting edge writes the queue, a later one loads the output register)
// the field decode is a single state register step per byte: length shift-add or
//   string countdown, so nothing iterates
// synchronous active-low reset returns to waiting for a representation byte, queue empty
// o_stall rises only when the queue holds QUEUE_DEPTH words; the output register keeps
//   draining the queue while its word is taken
`timescale 1ns / 1ps

module hpack_literal_header_decoder #(
    parameter int QUEUE_DEPTH = 4   // 2 to 16 result words
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_block_end,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_string_end,
    output logic        o_field_end
);

    // front to queue
    logic            q_push;
    hlhd_pkg::t_cmd  q_wdata;
    logic            q_full;
    // queue to back
    logic            q_pop;
    logic            q_empty;
    hlhd_pkg::t_cmd  q_rdata;

    // phase tracking and byte classification
    hlhd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_block_end (i_block_end),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_wdata)
    );

    // decouples the front from output stalls
    hlhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    // formatting and the output register
    hlhd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_cmd        (q_rdata),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_string_end (o_string_end),
        .o_field_end  (o_field_end)
    );

endmodule

@@ dv/tb_hpack_literal_header_decoder.sv @@
// self-checking testbench for hpack_literal_header_decoder: byte stream in, tagged results out
// depends on hlhd_pkg and the decoder rtl; a built-in field decoder predicts every result word
`timescale 1ns / 1ps

module tb_hpack_literal_header_decoder;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 80;     // long receiver hold-off, fills the result queue
    localparam int PIPE_SETTLE    = 8;      // settling wait before the final check for stray results
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no word moving on either side
    localparam int PHASE_BYTES    = 220;
    localparam int HOLD_BYTES     = 40;

    // decoder position inside a header field, mirrors the block's own sequencing
    typedef enum logic [2:0] {
        DEC_REP, DEC_NLEN, DEC_NCONT, DEC_NAME, DEC_VLEN, DEC_VCONT, DEC_VALUE, DEC_DROP
    } t_dec_phase;

    // shapes of generated header blocks
    typedef enum int {
        BLK_CLEAN, BLK_CUT, BLK_OVERFLOW, BLK_NOISE
    } t_block_style;

    typedef struct packed {
        logic [7:0] data;
        logic       blk_end;
    } t_in_word;

    typedef struct packed {
        hlhd_pkg::t_kind kind;
        logic [7:0]      data;
        logic            str_end;
        logic            fld_end;
    } t_result;

    // dut connections, every input known from time zero
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_block_end  = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_string_end;
    logic       o_field_end;

    // stimulus and scoreboard state
    t_in_word    pending_bytes [$];
    t_in_word    block_buf [$];
    t_result     expected_words [$];
    int unsigned pushed_total = 0;
    int unsigned bytes_taken  = 0;
    int unsigned block_count  = 0;
    int unsigned errors       = 0;
    int unsigned kind_count [5];
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned hold_id      = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    logic        in_taken     = 1'b0;

    // predicted decoder state
    t_dec_phase  dec_phase = DEC_REP;
    logic [31:0] len_acc   = '0;
    logic [2:0]  cont_cnt  = '0;
    logic [31:0] str_left  = '0;

    hpack_literal_header_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_block_end  (i_block_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_string_end (o_string_end),
        .o_field_end  (o_field_end)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // field decoder prediction
    // ------------------------------------------------------------------

    task automatic put_result(hlhd_pkg::t_kind k, logic [7:0] d, logic se, logic fe);
        t_result w;
        w.kind    = k;
        w.data    = d;
        w.str_end = se;
        w.fld_end = fe;
        expected_words.push_back(w);
    endtask

    // an error on the block's last byte restarts at once, otherwise the rest is dropped
    task automatic raise_error(hlhd_pkg::t_kind k, logic blk_end);
        dec_phase = blk_end ? DEC_REP : DEC_DROP;
        put_result(k, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic finish_length(logic [31:0] len, logic is_val, logic blk_end);
        len_acc  = '0;
        cont_cnt = '0;
        str_left = len;
        if (is_val && len == 32'd0) begin
            // empty value closes the field by itself
            dec_phase = DEC_REP;
            put_result(hlhd_pkg::KIND_EMPTY, 8'h00, 1'b0, 1'b1);
        end else begin
            // empty name skips straight to the value length, no result
            if (is_val)
                dec_phase = DEC_VALUE;
            else
                dec_phase = (len == 32'd0) ? DEC_VLEN : DEC_NAME;
            if (blk_end)
                raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
        end
    endtask

    // first length byte: bit 7 is the huffman flag and plays no part
    task automatic take_prefix(logic [7:0] b, logic is_val, logic blk_end);
        if (b[6:0] != hlhd_pkg::PREFIX_MAX) begin
            finish_length({25'd0, b[6:0]}, is_val, blk_end);
        end else begin
            len_acc   = {25'd0, hlhd_pkg::PREFIX_MAX};
            cont_cnt  = '0;
            dec_phase = is_val ? DEC_VCONT : DEC_NCONT;
            if (blk_end)
                raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
        end
    endtask

    // continuation digit, shift capped so the top three bits of the fifth digit fall off the top
    task automatic take_continuation(logic [7:0] b, logic is_val, logic blk_end);
        int unsigned shamt;
        shamt = hlhd_pkg::DIGIT_BITS * cont_cnt;
        if (shamt > hlhd_pkg::SHIFT_CAP)
            shamt = hlhd_pkg::SHIFT_CAP;
        len_acc  = len_acc + ({25'd0, b[6:0]} << shamt);
        cont_cnt = cont_cnt + 3'd1;
        if (!b[7])
            finish_length(len_acc, is_val, blk_end);
        else if (cont_cnt >= hlhd_pkg::MAX_CONT)
            raise_error(hlhd_pkg::KIND_OVFL, blk_end);   // wins over the block-end error
        else if (blk_end)
            raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
    endtask

    task automatic decode_byte(logic [7:0] b, logic blk_end);
        logic last;
        case (dec_phase)
            DEC_REP: begin
                // representation byte taken blindly
                dec_phase = DEC_NLEN;
                if (blk_end)
                    raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
            end
            DEC_NLEN:  take_prefix(b, 1'b0, blk_end);
            DEC_NCONT: take_continuation(b, 1'b0, blk_end);
            DEC_NAME: begin
                // a name byte can never end a block cleanly
                if (blk_end) begin
                    raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
                end else begin
                    last     = (str_left == 32'd1);
                    str_left = str_left - 32'd1;
                    if (last)
                        dec_phase = DEC_VLEN;
                    put_result(hlhd_pkg::KIND_NAME, b, last, 1'b0);
                end
            end
            DEC_VLEN:  take_prefix(b, 1'b1, blk_end);
            DEC_VCONT: take_continuation(b, 1'b1, blk_end);
            DEC_VALUE: begin
                last = (str_left == 32'd1);
                if (blk_end && !last) begin
                    raise_error(hlhd_pkg::KIND_INCOMP, 1'b1);
                end else begin
                    str_left = str_left - 32'd1;
                    if (last)
                        dec_phase = DEC_REP;
                    put_result(hlhd_pkg::KIND_VALUE, b, last, last);
                end
            end
            default: begin
                // dropping the remainder of a failed block
                if (blk_end)
                    dec_phase = DEC_REP;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // header block generation
    // ------------------------------------------------------------------

    task automatic push_byte(logic [7:0] d, logic e);
        t_in_word w;
        w.data    = d;
        w.blk_end = e;
        pending_bytes.push_back(w);
        pushed_total++;
        if (e)
            block_count++;
    endtask

    task automatic add_byte(logic [7:0] d);
        t_in_word w;
        w.data    = d;
        w.blk_end = 1'b0;
        block_buf.push_back(w);
    endtask

    // mostly short strings, now and then one long enough to need continuation bytes
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 0;
        if (r < 97)
            return $urandom_range(1, 6);
        return $urandom_range(1) ? 127 : $urandom_range(128, 135);
    endfunction

    function automatic t_block_style pick_style();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return BLK_CLEAN;
        if (r < 82)
            return BLK_CUT;
        if (r < 90)
            return BLK_OVERFLOW;
        return BLK_NOISE;
    endfunction

    task automatic add_length(int unsigned len);
        logic [7:0]  huff;
        logic [2:0]  top3;
        int unsigned rest;
        huff = $urandom_range(1) ? 8'h80 : 8'h00;
        top3 = $urandom_range(7);
        if (len < 127) begin
            add_byte(huff | len[7:0]);
        end else begin
            add_byte(huff | {1'b0, hlhd_pkg::PREFIX_MAX});
            rest = len - 127;
            if (rest == 0 && $urandom_range(2) == 0) begin
                // four zero digits, then a fifth whose set bits all shift past bit 31
                repeat (4) add_byte(8'h80);
                add_byte({1'b0, top3, 4'h0});
            end else begin
                while (rest >= 128) begin
                    add_byte({1'b1, rest[6:0]});
                    rest = rest >> 7;
                end
                // sometimes a redundant trailing zero digit
                if ($urandom_range(3) == 0) begin
                    add_byte({1'b1, rest[6:0]});
                    add_byte(8'h00);
                end else begin
                    add_byte({1'b0, rest[6:0]});
                end
            end
        end
    endtask

    task automatic add_string(int unsigned len);
        repeat (len) add_byte($urandom_range(255));
    endtask

    task automatic make_block(t_block_style style);
        int unsigned nfields;
        int unsigned nlen;
        int unsigned cut;
        block_buf.delete();
        if (style == BLK_NOISE) begin
            repeat ($urandom_range(1, 10)) add_byte($urandom_range(255));
        end else begin
            nfields = $urandom_range(1, 2);
            for (int f = 0; f < nfields; f++) begin
                add_byte($urandom_range(255));
                if (style == BLK_OVERFLOW && f == nfields - 1) begin
                    // runaway length in the name or the value, then trailing junk
                    if ($urandom_range(1)) begin
                        nlen = pick_len();
                        add_length(nlen);
                        add_string(nlen);
                    end
                    add_byte($urandom_range(1) ? 8'hFF : 8'h7F);
                    repeat (5) add_byte(8'h80 | 8'($urandom_range(127)));
                    add_string($urandom_range(0, 3));
                end else begin
                    nlen = pick_len();
                    add_length(nlen);
                    add_string(nlen);
                    nlen = pick_len();
                    add_length(nlen);
                    add_string(nlen);
                end
            end
            if (style == BLK_CUT) begin
                cut = $urandom_range(1, block_buf.size() - 1);
                while (block_buf.size() > cut)
                    void'(block_buf.pop_back());
            end
        end
        for (int i = 0; i < block_buf.size(); i++)
            push_byte(block_buf[i].data, i == block_buf.size() - 1);
    endtask

    task automatic fill_random(int unsigned target, logic clean_only);
        int unsigned start;
        start = pushed_total;
        while (pushed_total - start < target)
            make_block(clean_only ? BLK_CLEAN : pick_style());
    endtask

    // sender pause: nothing new until every byte is in and every result is out
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (bytes_taken != pushed_total || expected_words.size() != 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // input word driver, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : byte_driver
        t_in_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            // a stalled word holds; otherwise offer the next one or idle
            if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                w = pending_bytes.pop_front();
                i_valid     <= 1'b1;
                i_in_byte   <= w.data;
                i_block_end <= w.blk_end;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with a counted hold-off on request
    always @(negedge i_clk) begin : result_stall
        if (hold_seen != hold_id) begin
            hold_seen <= hold_id;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results, predict from accepted bytes, on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind    = hlhd_pkg::t_kind'(o_kind);
            got.data    = o_out_byte;
            got.str_end = o_string_end;
            got.fld_end = o_field_end;
            if (expected_words.size() == 0) begin
                $display("%0t: result with nothing expected: kind %0d byte %02h %s %b %b",
                         $time, o_kind, o_out_byte, "str_end/fld_end", o_string_end,
                         o_field_end);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected kind %0d byte %02h %s %b %b",
                             $time, want.kind, want.data, "str_end/fld_end",
                             want.str_end, want.fld_end);
                    $display("%0t:                  actual kind %0d byte %02h %s %b %b",
                             $time, o_kind, o_out_byte, "str_end/fld_end",
                             o_string_end, o_field_end);
                    errors++;
                end
                kind_count[int'(want.kind)]++;
            end
        end
        // a byte's result passes through the queue and the output register, so checking first is safe
        if (i_rst_n && i_valid && !o_stall) begin
            decode_byte(i_in_byte, i_block_end);
            bytes_taken++;
        end
    end

    // watchdog on cycles where no word moves
    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_words.size());
        $display("tb_hpack_literal_header_decoder: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty name then empty value with the huffman bit set
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        // one-byte name and value at the byte extremes
        push_byte(8'hFF, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        // block ends on its representation byte
        push_byte(8'h7E, 1'b1);
        // continued name length cut off by the block end
        push_byte(8'h40, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b1);
        // too many continuation digits, overflow and block end on the same byte
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b1);
        // block ends inside the name
        push_byte(8'h10, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        wait_drained();

        // receiver holds off while the sender keeps offering, input must back up
        fill_random(HOLD_BYTES, 1'b1);
        hold_id++;
        wait_drained();

        // slow receiver, mostly busy sender
        tx_idle_pct = 23;
        rx_idle_pct = 81;
        fill_random(PHASE_BYTES, 1'b0);
        wait_drained();

        // slow sender, mostly ready receiver
        tx_idle_pct = 81;
        rx_idle_pct = 23;
        fill_random(PHASE_BYTES, 1'b0);
        wait_drained();

        // full rate both ways
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_random(PHASE_BYTES, 1'b0);
        wait_drained();

        // catch any stray result after the last expected one
        repeat (PIPE_SETTLE) @(posedge i_clk);

        $display("run: %0d bytes in %0d header blocks, %s",
                 bytes_taken, block_count,
                 "directed cases plus hold-off and three pacing mixes");
        $display("results: %0d name, %0d value, %0d empty value, %0d incomplete, %0d overflow",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_hpack_literal_header_decoder: done, clean");
        else
            $display("tb_hpack_literal_header_decoder: done, errors");
        $finish;
    end

endmodule
